### hw/rtl/u8dec_pkg.sv
// shared types, constants and decode functions of the utf-8 decoder
package u8dec_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam logic [15:0] MAX_COUNT_RST = 16'hFFFF;
	localparam logic [20:0] REPL_CHAR = 21'h00FFFD;

	typedef struct packed {
		logic load;
		logic step;
		logic end_rec;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic flush;
		logic limit_hit;
		logic out_free;
	} dp_stat_t;

	// sequence length from the lead byte's top nibble, 0 for a stray continuation byte
	function automatic logic [2:0] seq_len(input logic [7:0] lead);
		logic [2:0] len;
		case (lead[7:4])
			4'h8, 4'h9, 4'hA, 4'hB: len = 3'd0;
			4'hC, 4'hD: len = 3'd2;
			4'hE: len = 3'd3;
			4'hF: len = 3'd4;
			default: len = 3'd1;
		endcase
		return len;
	endfunction

	function automatic logic packed_ok(input logic [31:0] c);
		logic ok;
		if (c <= 32'h0000007F)
			ok = 1'b1;
		else if (c >= 32'h0000C280 && c <= 32'h0000DFBF)
			ok = (c & 32'h0000E0C0) == 32'h0000C080;
		else if (c >= 32'h00EDA080 && c <= 32'h00EDBFBF)
			ok = 1'b0;
		else if (c >= 32'h00E0A080 && c <= 32'h00EFBFBF)
			ok = (c & 32'h00F0C0C0) == 32'h00E08080;
		else if (c >= 32'hF0908080 && c <= 32'hF48FBFBF)
			ok = (c & 32'hF8C0C0C0) == 32'hF0808080;
		else
			ok = 1'b0;
		return ok;
	endfunction

	function automatic logic [20:0] packed_value(input logic [31:0] c);
		logic [31:0] m;
		logic [31:0] v;
		m = (c <= 32'h00EFBFBF) ? 32'h000F0000 : 32'h003F0000;
		if (c <= 32'h0000007F)
			v = c;
		else
			v = ((c & 32'h07000000) >> 6) | ((c & m) >> 4) |
				((c & 32'h00003F00) >> 2) | (c & 32'h0000003F);
		return v[20:0];
	endfunction

endpackage

### hw/rtl/u8dec_ctrl.sv
// controller state machine of the utf-8 decoder
module u8dec_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  u8dec_pkg::dp_stat_t stat,
	output u8dec_pkg::dp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_END
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_SCAN: begin
				// dropping at the limit needs no output slot
				if (!stat.scan_done && (stat.limit_hit || stat.out_free))
					cmd.step = 1'b1;
			end
			S_END: begin
				cmd.end_rec = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (stat.scan_done)
						state_q <= stat.flush ? S_END : S_IDLE;
				end
				S_END: begin
					if (stat.out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/u8dec_dp.sv
// datapath of the utf-8 decoder: byte window, sequence check, counters, output register
module u8dec_dp #(
	parameter int COUNT_BITS = u8dec_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  u8dec_pkg::dp_cmd_t  cmd,
	output u8dec_pkg::dp_stat_t stat,
	input  logic [7:0]         text_byte,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [20:0]        code_point,
	output logic               replaced,
	output logic               end_record,
	output logic               complete,
	output logic [15:0]        emitted_count
);

	logic [7:0]            win_q [4];
	logic [2:0]            n_q;
	logic                  flush_q;
	logic [COUNT_BITS-1:0] point_count_q;
	logic                  bytes_dropped_q;
	logic [15:0]           max_count_q;
	logic                  out_valid_q;
	logic [20:0]           code_point_q;
	logic                  replaced_q;
	logic                  end_record_q;
	logic                  complete_q;
	logic [15:0]           emitted_count_q;

	logic [2:0]            len;
	logic [31:0]           pk;
	logic                  seq_ok;
	logic [2:0]            drop;
	logic                  limit_hit;
	logic [COUNT_BITS-1:0] pc_next;
	logic [31:0]           pc_ext;
	logic [31:0]           pc_next_ext;
	logic                  emit;

	always_comb begin
		len = u8dec_pkg::seq_len(win_q[0]);
		case (len)
			3'd2: pk = {16'h0000, win_q[0], win_q[1]};
			3'd3: pk = {8'h00, win_q[0], win_q[1], win_q[2]};
			3'd4: pk = {win_q[0], win_q[1], win_q[2], win_q[3]};
			default: pk = {24'h000000, win_q[0]};
		endcase
	end

	assign seq_ok = (len != 3'd0) && (len <= n_q) && u8dec_pkg::packed_ok(pk);
	// an invalid sequence consumes only its lead byte
	assign drop = seq_ok ? len : 3'd1;
	assign pc_next = point_count_q + COUNT_BITS'(1);
	assign pc_ext = 32'(point_count_q);
	assign pc_next_ext = 32'(pc_next);
	assign limit_hit = pc_ext >= 32'(max_count_q);
	assign emit = cmd.step && !limit_hit;

	always_comb begin
		stat.scan_done = (n_q == 3'd0) ||
			(!limit_hit && len != 3'd0 && len > n_q && !flush_q);
		stat.flush = flush_q;
		stat.limit_hit = limit_hit;
		stat.out_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			flush_q <= 1'b0;
			point_count_q <= '0;
			bytes_dropped_q <= 1'b0;
			max_count_q <= u8dec_pkg::MAX_COUNT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				max_count_q <= cfg_wr_data;
			if (cmd.load) begin
				if (text_byte == 8'h00)
					flush_q <= 1'b1;
				else
					n_q <= n_q + 3'd1;
			end
			if (cmd.step) begin
				if (limit_hit) begin
					n_q <= '0;
					bytes_dropped_q <= 1'b1;
				end else begin
					n_q <= n_q - drop;
					point_count_q <= pc_next;
				end
			end
			if (cmd.end_rec) begin
				n_q <= '0;
				flush_q <= 1'b0;
				point_count_q <= '0;
				bytes_dropped_q <= 1'b0;
			end
			if (emit || cmd.end_rec)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && text_byte != 8'h00)
			win_q[n_q[1:0]] <= text_byte;
		if (emit) begin
			case (drop)
				3'd1: begin
					win_q[0] <= win_q[1];
					win_q[1] <= win_q[2];
					win_q[2] <= win_q[3];
				end
				3'd2: begin
					win_q[0] <= win_q[2];
					win_q[1] <= win_q[3];
				end
				3'd3: begin
					win_q[0] <= win_q[3];
				end
				default: begin
					// a four-byte sequence empties the window
				end
			endcase
			code_point_q <= seq_ok ? u8dec_pkg::packed_value(pk) : u8dec_pkg::REPL_CHAR;
			replaced_q <= !seq_ok;
			end_record_q <= 1'b0;
			complete_q <= 1'b0;
			emitted_count_q <= pc_next_ext[15:0];
		end
		if (cmd.end_rec) begin
			code_point_q <= '0;
			replaced_q <= 1'b0;
			end_record_q <= 1'b1;
			complete_q <= !bytes_dropped_q;
			emitted_count_q <= pc_ext[15:0];
		end
	end

	assign out_valid = out_valid_q;
	assign code_point = code_point_q;
	assign replaced = replaced_q;
	assign end_record = end_record_q;
	assign complete = complete_q;
	assign emitted_count = emitted_count_q;

endmodule

### hw/rtl/utf8_to_codepoint_decoder.sv
// a byte is written into the window register, and the scan state then writes its first result to the output register
// the input stalls until the scan of a byte ends; each result and each drop at the limit take a scan step
// a nul byte first flushes the held bytes as results, then the end state issues the end record
// the window scan issues one result per cycle and waits while the output register is full and stalled
// reset clears counters and flags and sets max_count to 65535; the window bytes themselves are not reset
module utf8_to_codepoint_decoder #(
	parameter int COUNT_BITS = u8dec_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [20:0] code_point,
	output logic        replaced,
	output logic        end_record,
	output logic        complete,
	output logic [15:0] emitted_count
);

	u8dec_pkg::dp_cmd_t  cmd;
	u8dec_pkg::dp_stat_t stat;

	u8dec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	u8dec_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.text_byte     (text_byte),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.code_point    (code_point),
		.replaced      (replaced),
		.end_record    (end_record),
		.complete      (complete),
		.emitted_count (emitted_count)
	);

`ifndef SYNTH
	a_end_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_record |-> code_point == 21'd0 && !replaced)
		else $error("end record carries a code point");

	a_repl_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && replaced |-> code_point == u8dec_pkg::REPL_CHAR && !end_record)
		else $error("replaced result without replacement character");

	a_end_issue: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.end_rec |=> out_valid && end_record)
		else $error("end record not presented after issue");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step || cmd.end_rec |-> !cmd.load && in_stall)
		else $error("input transfer while scanning");
`endif

endmodule

### tb/tb.sv
// self-checking testbench for the utf-8 to code point decoder
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	// opening text: ascii max, 2/3/4-byte extremes, surrogate, overlong,
	// too-large value, stray continuation, and a 4-byte lead followed by a 2-byte character and nul
	localparam logic [191:0] OPENING_TEXT = {
		8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hED, 8'hA0, 8'h80,
		8'hC0, 8'hAF, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF4, 8'h90, 8'h80,
		8'h80, 8'h80, 8'hF0, 8'hC3, 8'hA9, 8'h00};

	typedef struct packed {
		logic [20:0] cp;
		logic        rep;
		logic        last;
		logic        whole;
		logic [15:0] count;
	} point_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [20:0] code_point;
	logic        replaced;
	logic        end_record;
	logic        complete;
	logic [15:0] emitted_count;

	utf8_to_codepoint_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_byte    (text_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_point   (code_point),
		.replaced     (replaced),
		.end_record   (end_record),
		.complete     (complete),
		.emitted_count(emitted_count)
	);

	// decoder state as the checker sees it
	logic [15:0] max_cap = u8dec_pkg::MAX_COUNT_RST;
	logic [7:0]  win [0:3];
	int          win_n = 0;
	logic [15:0] pts = '0;
	bit          dropped = 1'b0;

	point_rec_t  pending_points [$];
	logic [7:0]  byte_q [$];
	int          fed_total = 0;
	int          taken_total = 0;
	int          mismatches = 0;
	logic        in_taken = 1'b0;
	int          in_gap = 0;
	int          out_hold = 0;
	int          quiet = 0;
	bit          calm = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic int lead_len(input logic [7:0] b);
		if (b < 8'h80) return 1;
		if (b < 8'hC0) return 0;
		if (b < 8'hE0) return 2;
		if (b < 8'hF0) return 3;
		return 4;
	endfunction

	function automatic bit is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	// value of the len bytes at the head of the window, and whether they form a legal scalar
	function automatic bit seq_value(input int len, output logic [20:0] cp);
		bit ok;
		cp = '0;
		ok = 1'b0;
		case (len)
			1: begin
				cp = {13'd0, win[0]};
				ok = 1'b1;
			end
			2: begin
				cp = {10'd0, win[0][4:0], win[1][5:0]};
				ok = is_cont(win[1]) && cp >= 21'h80;
			end
			3: begin
				cp = {5'd0, win[0][3:0], win[1][5:0], win[2][5:0]};
				ok = is_cont(win[1]) && is_cont(win[2]) && cp >= 21'h800 &&
					!(cp >= 21'hD800 && cp <= 21'hDFFF);
			end
			4: begin
				cp = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
				ok = !win[0][3] && is_cont(win[1]) && is_cont(win[2]) &&
					is_cont(win[3]) && cp >= 21'h10000 && cp <= 21'h10FFFF;
			end
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic void add_point(input logic [20:0] cp, input logic rep);
		point_rec_t r;
		pts = pts + 16'd1;
		r.cp = cp;
		r.rep = rep;
		r.last = 1'b0;
		r.whole = 1'b0;
		r.count = pts;
		pending_points.push_back(r);
	endfunction

	// consume the held window; without flush an unfinished sequence stays held
	function automatic void scan_window(input bit flush);
		int len;
		int drop;
		int i;
		logic [20:0] cp;
		while (win_n > 0) begin
			if (pts >= max_cap) begin
				dropped = 1'b1;
				win_n = 0;
				break;
			end
			len = lead_len(win[0]);
			if (len != 0 && len > win_n && !flush)
				break;
			drop = 1;
			if (len != 0 && len <= win_n && seq_value(len, cp)) begin
				add_point(cp, 1'b0);
				drop = len;
			end else begin
				add_point(u8dec_pkg::REPL_CHAR, 1'b1);
			end
			for (i = 0; i + drop < 4; i++)
				win[i] = win[i + drop];
			win_n -= drop;
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		point_rec_t r;
		if (b != 8'h00) begin
			win[win_n] = b;
			win_n++;
			scan_window(1'b0);
		end else begin
			scan_window(1'b1);
			r.cp = '0;
			r.rep = 1'b0;
			r.last = 1'b1;
			r.whole = !dropped;
			r.count = pts;
			pending_points.push_back(r);
			win_n = 0;
			pts = '0;
			dropped = 1'b0;
		end
	endfunction

	task automatic check_field(input string fname, input logic [20:0] want,
			input logic [20:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 40)
				$error("%s: expected 0x%0h, actual 0x%0h", fname, want, got);
		end
	endtask

	// input side: byte transfers feed the predictor
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			decode_byte(text_byte);
			taken_total <= taken_total + 1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (byte_q.size() != 0) begin
				in_valid <= 1'b1;
				text_byte <= byte_q.pop_front();
				in_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: random backpressure and result checks
	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_stall <= 1'b1;
			out_hold <= out_hold - 1;
		end else begin
			out_stall <= 1'b0;
			out_hold <= pick_gap();
		end
	end

	always @(posedge clk) begin : result_check
		point_rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$error("unexpected result: code_point 0x%0h", code_point);
			end else begin
				want = pending_points.pop_front();
				check_field("code_point", want.cp, code_point);
				check_field("replaced", 21'(want.rep), 21'(replaced));
				check_field("end_record", 21'(want.last), 21'(end_record));
				check_field("complete", 21'(want.whole), 21'(complete));
				check_field("emitted_count", 21'(want.count), 21'(emitted_count));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic feed(input logic [7:0] b);
		byte_q.push_back(b);
		fed_total++;
	endtask

	function automatic logic [7:0] rand_cont();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	// utf-8 encoding of cp, optionally with its last byte cut off
	task automatic feed_point(input int unsigned cp, input bit cut);
		logic [7:0] b [0:3];
		int n;
		int i;
		if (cp < 32'h80) begin
			b[0] = cp[7:0];
			n = 1;
		end else if (cp < 32'h800) begin
			b[0] = 8'hC0 | cp[10:6];
			b[1] = 8'h80 | cp[5:0];
			n = 2;
		end else if (cp < 32'h10000) begin
			b[0] = 8'hE0 | cp[15:12];
			b[1] = 8'h80 | cp[11:6];
			b[2] = 8'h80 | cp[5:0];
			n = 3;
		end else begin
			b[0] = 8'hF0 | cp[20:18];
			b[1] = 8'h80 | cp[17:12];
			b[2] = 8'h80 | cp[11:6];
			b[3] = 8'h80 | cp[5:0];
			n = 4;
		end
		if (cut && n > 1)
			n--;
		for (i = 0; i < n; i++)
			feed(b[i]);
	endtask

	// mostly well-formed characters, some malformed ones
	task automatic add_char();
		int r;
		int unsigned cp;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			feed_point($urandom_range(1, 32'h7F), 1'b0);
		end else if (r < 50) begin
			feed_point($urandom_range(32'h80, 32'h7FF), 1'b0);
		end else if (r < 68) begin
			cp = $urandom_range(32'h800, 32'hFFFF);
			if (cp >= 32'hD800 && cp <= 32'hDFFF)
				cp = cp ^ 32'h2000;
			feed_point(cp, 1'b0);
		end else if (r < 80) begin
			feed_point($urandom_range(32'h10000, 32'h10FFFF), 1'b0);
		end else if (r < 84) begin
			feed_point($urandom_range(32'hD800, 32'hDFFF), 1'b0);
		end else if (r < 88) begin
			// overlong forms
			case ($urandom_range(0, 2))
				0: begin
					feed(8'hC0 | 8'($urandom_range(0, 1)));
					feed(rand_cont());
				end
				1: begin
					feed(8'hE0);
					feed(8'h80 | 8'($urandom_range(0, 31)));
					feed(rand_cont());
				end
				default: begin
					feed(8'hF0);
					feed(8'h80 | 8'($urandom_range(0, 15)));
					feed(rand_cont());
					feed(rand_cont());
				end
			endcase
		end else if (r < 91) begin
			feed_point($urandom_range(32'h110000, 32'h1FFFFF), 1'b0);
		end else if (r < 94) begin
			feed(rand_cont());
		end else if (r < 97) begin
			feed_point($urandom_range(32'h80, 32'h10FFFF), 1'b1);
		end else begin
			feed(8'($urandom_range(1, 255)));
		end
	endtask

	task automatic wait_drained();
		while (taken_total != fed_total || pending_points.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_max_count(input logic [15:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		max_cap = v;
	endtask

	initial begin
		int p;
		int i;
		int start;
		logic [15:0] cap;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_max_count(16'hFFFF);
		for (i = 23; i >= 0; i--)
			feed(OPENING_TEXT[i * 8 +: 8]);

		for (p = 0; p < 6; p++) begin
			case (p)
				0: cap = 16'd0;
				1: cap = 16'd1;
				2: cap = 16'($urandom_range(2, 4));
				3: cap = 16'hFFFF;
				4: cap = 16'($urandom_range(2, 8));
				default: cap = 16'hFFFF;
			endcase
			// a phase may end mid-string, so the limit can change with bytes held
			write_max_count(cap);
			calm = ($urandom_range(0, 3) == 0);
			start = fed_total;
			while (fed_total - start < 28) begin
				repeat ($urandom_range(0, 6)) add_char();
				if (fed_total - start < 28 || $urandom_range(0, 1) == 0)
					feed(8'h00);
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
